// ===== src/qse_pkg.sv =====
`timescale 1ns / 1ps
package qse_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef enum logic [2:0] {
    PH_LOAD,
    PH_SORT,
    PH_OUT_RD,
    PH_OUT
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RANGE,
    S_PIV,
    S_I_RD,
    S_I_CMP,
    S_J_CMP,
    S_SWAP2,
    S_SPLIT,
    S_INS_NEXT,
    S_INS_KEY,
    S_INS_CMP,
    S_INS_PUT
  } sort_state_t;

endpackage

// ===== src/qse_store.sv =====
`timescale 1ns / 1ps
module qse_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic [AW-1:0]               rd_addr,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [qse_pkg::VALUE_W-1:0] wr_data,
  output logic [qse_pkg::VALUE_W-1:0] rd_data
);

  logic [qse_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [qse_pkg::VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/qse_sort.sv =====
`timescale 1ns / 1ps
module qse_sort #(
  parameter int DEPTH       = 64,
  parameter int STACK_DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [$clog2(DEPTH)-1:0]           start_hi,
  output logic                               done,
  output logic [$clog2(DEPTH)-1:0]           mem_rd_addr,
  output logic                               mem_wr_en,
  output logic [$clog2(DEPTH)-1:0]           mem_wr_addr,
  output logic [qse_pkg::VALUE_W-1:0]        mem_wr_data,
  input  logic [qse_pkg::VALUE_W-1:0]        mem_rd_data
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = $clog2(STACK_DEPTH);

  qse_pkg::sort_state_t state_r, state_nxt;

  logic [AW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [AW-1:0] ins_lo_r, ins_lo_nxt, ins_hi_r, ins_hi_nxt;
  logic [AW-1:0] h_r, h_nxt;
  logic [CW-1:0] a_r, a_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [qse_pkg::VALUE_W-1:0] pivot_r, pivot_nxt, vi_r, vi_nxt, key_r, key_nxt;

  logic [AW-1:0] stk_lo_r [STACK_DEPTH];
  logic [AW-1:0] stk_hi_r [STACK_DEPTH];
  logic          push_en;
  logic [SIW-1:0] push_idx, pop_idx;
  logic [AW-1:0] push_lo, push_hi;

  logic [AW-1:0] left_len, right_len, big_lo, big_hi, small_lo, small_hi;
  logic          left_big;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qse_pkg::S_IDLE;
      sp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    ins_lo_r <= ins_lo_nxt;
    ins_hi_r <= ins_hi_nxt;
    h_r      <= h_nxt;
    a_r      <= a_nxt;
    pivot_r  <= pivot_nxt;
    vi_r     <= vi_nxt;
    key_r    <= key_nxt;
    if (push_en) begin
      stk_lo_r[push_idx] <= push_lo;
      stk_hi_r[push_idx] <= push_hi;
    end
  end

  assign push_idx  = sp_r[SIW-1:0];
  assign pop_idx   = SIW'(sp_r - SPW'(1));
  assign left_len  = j_r - lo_r;
  assign right_len = hi_r - j_r - AW'(1);
  assign left_big  = (left_len >= right_len);
  assign big_lo    = left_big ? lo_r : j_r + AW'(1);
  assign big_hi    = left_big ? j_r : hi_r;
  assign small_lo  = left_big ? j_r + AW'(1) : lo_r;
  assign small_hi  = left_big ? hi_r : j_r;

  always_comb begin
    state_nxt   = state_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    ins_lo_nxt  = ins_lo_r;
    ins_hi_nxt  = ins_hi_r;
    h_nxt       = h_r;
    a_nxt       = a_r;
    sp_nxt      = sp_r;
    pivot_nxt   = pivot_r;
    vi_nxt      = vi_r;
    key_nxt     = key_r;
    push_en     = 1'b0;
    push_lo     = big_lo;
    push_hi     = big_hi;
    done        = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = mem_rd_data;
    case (state_r)
      qse_pkg::S_IDLE: begin
        if (start) begin
          lo_nxt    = '0;
          hi_nxt    = start_hi;
          sp_nxt    = '0;
          state_nxt = qse_pkg::S_RANGE;
        end
      end
      qse_pkg::S_RANGE: begin
        if (lo_r < hi_r) begin
          mem_rd_addr = lo_r;
          state_nxt   = qse_pkg::S_PIV;
        end else if (sp_r == '0) begin
          done      = 1'b1;
          state_nxt = qse_pkg::S_IDLE;
        end else begin
          sp_nxt = sp_r - SPW'(1);
          lo_nxt = stk_lo_r[pop_idx];
          hi_nxt = stk_hi_r[pop_idx];
        end
      end
      qse_pkg::S_PIV: begin
        pivot_nxt   = mem_rd_data;
        i_nxt       = lo_r;
        j_nxt       = hi_r;
        mem_rd_addr = lo_r;
        state_nxt   = qse_pkg::S_I_CMP;
      end
      qse_pkg::S_I_RD: begin
        mem_rd_addr = i_r;
        state_nxt   = qse_pkg::S_I_CMP;
      end
      qse_pkg::S_I_CMP: begin
        if ($signed(mem_rd_data) < $signed(pivot_r)) begin
          i_nxt       = i_r + AW'(1);
          mem_rd_addr = i_r + AW'(1);
        end else begin
          vi_nxt      = mem_rd_data;
          mem_rd_addr = j_r;
          state_nxt   = qse_pkg::S_J_CMP;
        end
      end
      qse_pkg::S_J_CMP: begin
        if ($signed(mem_rd_data) > $signed(pivot_r)) begin
          j_nxt       = j_r - AW'(1);
          mem_rd_addr = j_r - AW'(1);
        end else if (i_r >= j_r) begin
          state_nxt = qse_pkg::S_SPLIT;
        end else begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = i_r;
          mem_wr_data = mem_rd_data;
          state_nxt   = qse_pkg::S_SWAP2;
        end
      end
      qse_pkg::S_SWAP2: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = j_r;
        mem_wr_data = vi_r;
        i_nxt       = i_r + AW'(1);
        j_nxt       = j_r - AW'(1);
        state_nxt   = qse_pkg::S_I_RD;
      end
      qse_pkg::S_SPLIT: begin
        lo_nxt = small_lo;
        hi_nxt = small_hi;
        if (sp_r < SPW'(STACK_DEPTH)) begin
          push_en   = 1'b1;
          sp_nxt    = sp_r + SPW'(1);
          state_nxt = qse_pkg::S_RANGE;
        end else begin
          ins_lo_nxt = big_lo;
          ins_hi_nxt = big_hi;
          a_nxt      = CW'(big_lo) + CW'(1);
          state_nxt  = qse_pkg::S_INS_NEXT;
        end
      end
      qse_pkg::S_INS_NEXT: begin
        if (a_r > CW'(ins_hi_r)) begin
          state_nxt = qse_pkg::S_RANGE;
        end else begin
          mem_rd_addr = a_r[AW-1:0];
          state_nxt   = qse_pkg::S_INS_KEY;
        end
      end
      qse_pkg::S_INS_KEY: begin
        key_nxt     = mem_rd_data;
        h_nxt       = a_r[AW-1:0];
        mem_rd_addr = a_r[AW-1:0] - AW'(1);
        state_nxt   = qse_pkg::S_INS_CMP;
      end
      qse_pkg::S_INS_CMP: begin
        if ($signed(mem_rd_data) > $signed(key_r)) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = h_r;
          mem_wr_data = mem_rd_data;
          h_nxt       = h_r - AW'(1);
          if ((h_r - AW'(1)) > ins_lo_r) begin
            mem_rd_addr = h_r - AW'(2);
          end else begin
            state_nxt = qse_pkg::S_INS_PUT;
          end
        end else begin
          state_nxt = qse_pkg::S_INS_PUT;
        end
      end
      qse_pkg::S_INS_PUT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = h_r;
        mem_wr_data = key_r;
        a_nxt       = a_r + CW'(1);
        state_nxt   = qse_pkg::S_INS_NEXT;
      end
      default: begin
        state_nxt = qse_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/quicksort_engine_top.sv =====
`timescale 1ns / 1ps
// Sorts up to DEPTH signed 32-bit values per set. Values load at one transfer per cycle;
// a set that exceeds DEPTH keeps its first DEPTH values and flags every result with
// out_overflowed. The transfer marked in_last starts an in-place quicksort (Hoare
// partition, first element as pivot, larger part pushed on a STACK_DEPTH-entry range
// stack, insertion sort when that stack is full). The sort runs on one store with a
// single read and a single write port and a registered read, so its time is set
// by those ports. Results then stream in ascending order, one per cycle while
// out_ready is high, after a read-priming state, with out_last_res on the greatest
// value. No input is taken while a set is being sorted or delivered.
module quicksort_engine_top #(
  parameter int DEPTH       = 64,
  parameter int STACK_DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [qse_pkg::VALUE_W-1:0] in_value,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [qse_pkg::VALUE_W-1:0] out_value_res,
  output logic                               out_last_res,
  output logic                               out_overflowed
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qse_pkg::phase_t phase_r, phase_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic          dropped_r, dropped_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic          in_xfer, out_xfer, sort_start, sort_done, is_last;

  logic [AW-1:0]               mem_rd_addr, mem_wr_addr;
  logic                        mem_wr_en;
  logic [qse_pkg::VALUE_W-1:0] mem_wr_data, mem_rd_data;

  logic [AW-1:0]               srt_rd_addr, srt_wr_addr;
  logic                        srt_wr_en;
  logic [qse_pkg::VALUE_W-1:0] srt_wr_data;

  qse_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_addr (mem_rd_addr),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  qse_sort #(
    .DEPTH       (DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_sort (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (sort_start),
    .start_hi    (AW'(count_nxt - CW'(1))),
    .done        (sort_done),
    .mem_rd_addr (srt_rd_addr),
    .mem_wr_en   (srt_wr_en),
    .mem_wr_addr (srt_wr_addr),
    .mem_wr_data (srt_wr_data),
    .mem_rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= qse_pkg::PH_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
      k_r       <= '0;
    end else begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      k_r       <= k_nxt;
    end
  end

  assign in_ready       = (phase_r == qse_pkg::PH_LOAD);
  assign out_valid      = (phase_r == qse_pkg::PH_OUT);
  assign in_xfer        = in_valid && in_ready;
  assign out_xfer       = out_valid && out_ready;
  assign is_last        = (CW'(k_r) == count_r - CW'(1));
  assign out_value_res  = mem_rd_data;
  assign out_last_res   = is_last;
  assign out_overflowed = dropped_r;

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    k_nxt       = k_r;
    sort_start  = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = count_r[AW-1:0];
    mem_wr_data = in_value;
    case (phase_r)
      qse_pkg::PH_LOAD: begin
        if (in_xfer) begin
          if (count_r < CW'(DEPTH)) begin
            mem_wr_en = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            sort_start = 1'b1;
            phase_nxt  = qse_pkg::PH_SORT;
          end
        end
      end
      qse_pkg::PH_SORT: begin
        mem_rd_addr = srt_rd_addr;
        mem_wr_en   = srt_wr_en;
        mem_wr_addr = srt_wr_addr;
        mem_wr_data = srt_wr_data;
        if (sort_done) begin
          k_nxt     = '0;
          phase_nxt = qse_pkg::PH_OUT_RD;
        end
      end
      qse_pkg::PH_OUT_RD: begin
        mem_rd_addr = k_r;
        phase_nxt   = qse_pkg::PH_OUT;
      end
      qse_pkg::PH_OUT: begin
        mem_rd_addr = k_r;
        if (out_xfer) begin
          if (is_last) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            k_nxt       = '0;
            phase_nxt   = qse_pkg::PH_LOAD;
          end else begin
            k_nxt       = k_r + AW'(1);
            mem_rd_addr = k_r + AW'(1);
          end
        end
      end
      default: begin
        phase_nxt = qse_pkg::PH_LOAD;
      end
    endcase
  end

endmodule

// ===== src/qse_checker.sv =====
`timescale 1ns / 1ps
module qse_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic signed [qse_pkg::VALUE_W-1:0] in_value,
  input logic                               in_last,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [qse_pkg::VALUE_W-1:0] out_value_res,
  input logic                               out_last_res,
  input logic                               out_overflowed
);

  // The input side and the result side are never open at the same time.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is offered");

  // A transfer marked last closes the input until the run is delivered.
  a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input still open after the final element");

  // The final result of a run returns the block to loading.
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_res) |=> (!out_valid && in_ready))
    else $error("block did not return to loading after the final result");

  // Within a run the results never decrease and the overflow flag holds.
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_res) ##1 out_valid |->
      ($past(out_value_res) <= out_value_res && $stable(out_overflowed)))
    else $error("results out of order within a run");

endmodule

bind quicksort_engine_top qse_checker u_qse_checker (.*);
